// ===== hw/rtl/lcp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcp_pkg: shared types and codes for the lease credit pool
// Command codes, status codes, credit lifecycle states, configuration
// register indexes and the controller/datapath handshake structs.
// ---------------------------------------------------------------------------
package lcp_pkg;

    // Request opcodes; codes above OP_RELEASE are rejected as bad envelope
    localparam logic [2:0] OP_ACQUIRE  = 3'd0;
    localparam logic [2:0] OP_COMMIT   = 3'd1;
    localparam logic [2:0] OP_ABORT    = 3'd2;
    localparam logic [2:0] OP_TRANSFER = 3'd3;
    localparam logic [2:0] OP_RELEASE  = 3'd4;

    // Result status codes
    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_ENVELOPE  = 3'd1;
    localparam logic [2:0] RC_OWNED     = 3'd2;
    localparam logic [2:0] RC_WRAPPED   = 3'd3;
    localparam logic [2:0] RC_EXHAUSTED = 3'd4;
    localparam logic [2:0] RC_STALE     = 3'd5;
    localparam logic [2:0] RC_DRIFTED   = 3'd6;

    // Plan kinds and their record limits
    localparam logic [1:0] KIND_SINGLE  = 2'd0;
    localparam logic [1:0] KIND_FIVE    = 2'd1;
    localparam logic [2:0] LIMIT_SINGLE = 3'd1;
    localparam logic [2:0] LIMIT_FIVE   = 3'd5;
    localparam logic [2:0] LIMIT_OTHER  = 3'd0;

    // Configuration register indexes
    localparam logic CFG_MAX_SLOTS = 1'b0;
    localparam logic CFG_MAX_BYTES = 1'b1;

    // Credit lifecycle
    typedef enum logic [1:0] {
        LS_FREE = 2'd0,
        LS_PREP = 2'd1,
        LS_COMM = 2'd2,
        LS_XFER = 2'd3
    } t_life;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the request
        logic scan_clr;  // clear scan counter and trackers
        logic scan_rd;   // read the credit at the scan counter
        logic lease_rd;  // read the credit named by the lease
        logic commit;    // write the updated credit and free count
        logic respond;   // register the result and pulse done
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_acq;     // captured request is an acquire
        logic early_exit; // result is known without a credit read
        logic scan_last;  // scan counter is at the last credit
        logic ok;         // final status is RC_OK
    } t_dp_stat;

endpackage

// ===== hw/rtl/lcp_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ---------------------------------------------------------------------------
module lcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lcp_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcp_ctrl: request sequencer for the lease credit pool
// Steps each request through decode, credit scan or lease read, and the
// final update/response cycle; early exits respond straight from decode.
// ---------------------------------------------------------------------------
module lcp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lcp_pkg::t_dp_stat i_stat,
    output lcp_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_END,
        S_ACQ_FIN,
        S_LEASE_CHK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.early_exit) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_stat.is_acq) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.lease_rd = 1'b1;
                    n_state        = S_LEASE_CHK;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_ACQ_FIN;
            end
            S_ACQ_FIN, S_LEASE_CHK: begin
                o_cmd.respond = 1'b1;
                o_cmd.commit  = i_stat.ok;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

    // A request accepted while idle makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but block not busy");

    // Busy falls only after a response cycle
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(o_cmd.respond))
        else $error("busy dropped without a response");

    // A credit update happens only together with a response
    a_commit_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> o_cmd.respond)
        else $error("credit written outside the response cycle");

endmodule

// ===== hw/rtl/lcp_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcp_dp: datapath of the lease credit pool
// Request and configuration registers, credit RAM with per-entry valid bits,
// scan trackers, identity compare, free counter and result registers.
// ---------------------------------------------------------------------------
module lcp_dp #(
    parameter int CREDITS   = 16,
    parameter int TAG_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcp_pkg::t_dp_cmd  i_cmd,
    output lcp_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    input  logic [2:0]        i_cmd_code,
    input  logic [31:0]       i_plan_id,
    input  logic [1:0]        i_plan_kind,
    input  logic [7:0]        i_record_count,
    input  logic [15:0]       i_slot_count,
    input  logic [31:0]       i_byte_count,
    input  logic [7:0]        i_lease_index,
    input  logic [31:0]       i_lease_tag,
    output logic              o_done,
    output logic [2:0]        o_status,
    output logic [7:0]        o_granted_index,
    output logic [31:0]       o_granted_tag,
    output logic [8:0]        o_free_count
);

    localparam int IDX_W = (CREDITS > 1) ? $clog2(CREDITS) : 1;
    localparam int FC_W  = $clog2(CREDITS + 1);
    localparam int CMP_W = (TAG_WIDTH > 32) ? TAG_WIDTH : 32;

    typedef struct packed {
        logic [1:0]           life;
        logic [TAG_WIDTH-1:0] tag;
        logic [31:0]          plan;
        logic [2:0]           recs;
        logic [15:0]          slots;
        logic [31:0]          bytes;
    } t_rec;

    // Configuration
    logic [15:0] r_max_slots;
    logic [31:0] r_max_bytes;

    // Captured request
    logic [2:0]  r_op;
    logic [31:0] r_plan;
    logic [1:0]  r_kind;
    logic [7:0]  r_recs;
    logic [15:0] r_slots;
    logic [31:0] r_bytes;
    logic [7:0]  r_lidx;
    logic [31:0] r_ltag;

    // Credit store
    logic [CREDITS-1:0] r_valid;
    logic               r_rd_valid;
    logic [IDX_W-1:0]   r_rd_addr;
    logic               r_rd_scan;
    t_rec               w_ram_q;
    t_rec               w_rd;
    t_rec               w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    logic [IDX_W-1:0]   w_waddr;
    logic               w_re;

    // Scan trackers
    logic [IDX_W-1:0]     r_scan_cnt;
    logic                 r_owned;
    logic                 r_found;
    logic [IDX_W-1:0]     r_free_idx;
    logic [TAG_WIDTH-1:0] r_free_tag;

    // Free counter and results
    logic [FC_W-1:0]      r_free;
    logic [FC_W-1:0]      n_free;
    logic                 r_done;
    logic [2:0]           r_status;
    logic [7:0]           r_gidx;
    logic [31:0]          r_gtag;

    logic                 w_is_acq;
    logic                 w_unknown;
    logic                 w_env_bad;
    logic                 w_stale;
    logic                 w_mismatch;
    logic [2:0]           w_limit;
    lcp_pkg::t_life       w_want;
    logic [2:0]           w_status;
    logic [TAG_WIDTH-1:0] w_new_tag;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_slots <= 16'hFFFF;
            r_max_bytes <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lcp_pkg::CFG_MAX_SLOTS) begin
                r_max_slots <= i_cfg_wdata[15:0];
            end else begin
                r_max_bytes <= i_cfg_wdata;
            end
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_cmd_code;
            r_plan  <= i_plan_id;
            r_kind  <= i_plan_kind;
            r_recs  <= i_record_count;
            r_slots <= i_slot_count;
            r_bytes <= i_byte_count;
            r_lidx  <= i_lease_index;
            r_ltag  <= i_lease_tag;
        end
    end

    // Envelope and index checks
    always_comb begin
        case (r_kind)
            lcp_pkg::KIND_SINGLE: w_limit = lcp_pkg::LIMIT_SINGLE;
            lcp_pkg::KIND_FIVE:   w_limit = lcp_pkg::LIMIT_FIVE;
            default:              w_limit = lcp_pkg::LIMIT_OTHER;
        endcase
    end

    assign w_is_acq  = (r_op == lcp_pkg::OP_ACQUIRE);
    assign w_unknown = (r_op != lcp_pkg::OP_ACQUIRE) && (r_op != lcp_pkg::OP_COMMIT) &&
                       (r_op != lcp_pkg::OP_ABORT) && (r_op != lcp_pkg::OP_TRANSFER) &&
                       (r_op != lcp_pkg::OP_RELEASE);
    assign w_env_bad = (r_plan == 32'd0) || (r_recs > 8'(w_limit)) ||
                       (r_slots == 16'd0) || (r_slots > r_max_slots) ||
                       (r_bytes == 32'd0) || (r_bytes > r_max_bytes);
    assign w_stale   = ({1'b0, r_lidx} >= 9'(CREDITS));

    // Credit RAM access; never-written entries read as a free, zeroed credit
    assign w_re    = i_cmd.scan_rd || i_cmd.lease_rd;
    assign w_raddr = i_cmd.scan_rd ? r_scan_cnt : r_lidx[IDX_W-1:0];
    assign w_rd    = r_rd_valid ? w_ram_q : '0;

    lcp_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (CREDITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_scan <= 1'b0;
        end else begin
            r_rd_scan <= i_cmd.scan_rd;
            if (i_cmd.commit) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_valid <= r_valid[w_raddr];
            r_rd_addr  <= w_raddr;
        end
    end

    // Scan: find an owning live credit and the lowest free credit
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_scan_cnt <= '0;
            r_owned    <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            if (r_rd_scan) begin
                if (w_rd.life != lcp_pkg::LS_FREE && w_rd.plan == r_plan) begin
                    r_owned <= 1'b1;
                end
                if (w_rd.life == lcp_pkg::LS_FREE && !r_found) begin
                    r_found    <= 1'b1;
                    r_free_idx <= r_rd_addr;
                    r_free_tag <= w_rd.tag;
                end
            end
        end
    end

    // Lease identity compare
    always_comb begin
        case (r_op)
            lcp_pkg::OP_TRANSFER: w_want = lcp_pkg::LS_COMM;
            lcp_pkg::OP_RELEASE:  w_want = lcp_pkg::LS_XFER;
            default:              w_want = lcp_pkg::LS_PREP;
        endcase
    end

    assign w_mismatch = (w_rd.life != w_want) ||
                        (CMP_W'(w_rd.tag) != CMP_W'(r_ltag)) ||
                        (w_rd.plan != r_plan) || (8'(w_rd.recs) != r_recs) ||
                        (w_rd.slots != r_slots) || (w_rd.bytes != r_bytes);

    // Final status
    always_comb begin
        if (w_unknown) begin
            w_status = lcp_pkg::RC_ENVELOPE;
        end else if (w_is_acq) begin
            if (w_env_bad) begin
                w_status = lcp_pkg::RC_ENVELOPE;
            end else if (r_owned) begin
                w_status = lcp_pkg::RC_OWNED;
            end else if (!r_found) begin
                w_status = lcp_pkg::RC_EXHAUSTED;
            end else if (&r_free_tag) begin
                w_status = lcp_pkg::RC_WRAPPED;
            end else begin
                w_status = lcp_pkg::RC_OK;
            end
        end else if (w_stale) begin
            w_status = lcp_pkg::RC_STALE;
        end else if (w_mismatch) begin
            w_status = lcp_pkg::RC_DRIFTED;
        end else begin
            w_status = lcp_pkg::RC_OK;
        end
    end

    assign o_stat.is_acq     = w_is_acq;
    assign o_stat.early_exit = w_unknown || (w_is_acq && w_env_bad) || (!w_is_acq && w_stale);
    assign o_stat.scan_last  = (r_scan_cnt == IDX_W'(CREDITS - 1));
    assign o_stat.ok         = (w_status == lcp_pkg::RC_OK);

    // Updated credit and free count
    assign w_new_tag = r_free_tag + 1'b1;

    always_comb begin
        w_wdata = w_rd;
        w_waddr = r_lidx[IDX_W-1:0];
        n_free  = r_free;
        case (r_op)
            lcp_pkg::OP_ACQUIRE: begin
                w_waddr       = r_free_idx;
                w_wdata.life  = lcp_pkg::LS_PREP;
                w_wdata.tag   = w_new_tag;
                w_wdata.plan  = r_plan;
                w_wdata.recs  = r_recs[2:0];
                w_wdata.slots = r_slots;
                w_wdata.bytes = r_bytes;
                n_free        = r_free - 1'b1;
            end
            lcp_pkg::OP_COMMIT: begin
                w_wdata.life = lcp_pkg::LS_COMM;
            end
            lcp_pkg::OP_ABORT: begin
                w_wdata.life = lcp_pkg::LS_FREE;
                n_free       = r_free + 1'b1;
            end
            lcp_pkg::OP_TRANSFER: begin
                w_wdata.life = lcp_pkg::LS_XFER;
            end
            lcp_pkg::OP_RELEASE: begin
                w_wdata       = '0;
                w_wdata.tag   = w_rd.tag;
                n_free        = r_free + 1'b1;
            end
            default: begin
                n_free = r_free;
            end
        endcase
        if (!i_cmd.commit) begin
            n_free = r_free;
        end
    end

    // Free counter and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= FC_W'(CREDITS);
            r_done <= 1'b0;
        end else begin
            r_free <= n_free;
            r_done <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_status <= w_status;
            if (w_is_acq && w_status == lcp_pkg::RC_OK) begin
                r_gidx <= 8'(r_free_idx);
                r_gtag <= 32'(w_new_tag);
            end else begin
                r_gidx <= 8'd0;
                r_gtag <= 32'd0;
            end
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_index = r_gidx;
    assign o_granted_tag   = r_gtag;
    assign o_free_count    = 9'(r_free);

    // Free count never exceeds the pool size
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FC_W'(CREDITS))
        else $error("free count above pool size");

    // The credit store is never read and written in the same cycle
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit && w_re))
        else $error("credit read and write collide");

    // Failed results carry no grant
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != lcp_pkg::RC_OK) |-> (o_granted_tag == 32'd0))
        else $error("grant reported on a failed request");

endmodule

// ===== hw/rtl/lease_credit_pool_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lease_credit_pool_core: generation-tagged lease credit pool
// Top level joining the request sequencer and the credit datapath.
// ---------------------------------------------------------------------------
// A request is taken when start is high while busy is low; its single
// result appears on the o_ ports for one cycle with o_done, and the receiver
// cannot stall it. A rejected acquire, an unknown command or an out-of-range
// lease index is answered straight from decode; commit, abort, transfer and
// release make one registered credit RAM read, then the compare and write.
// An acquire that passes its envelope check walks the credit RAM one entry
// per cycle through its single read port, looking for a live credit of the
// same plan and the lowest free credit, then takes the last read in
// S_SCAN_END and the update and response in S_ACQ_FIN. A new request may
// start in the cycle o_done is high. Credits start free after reset with no
// clearing pass; configuration writes take effect at once and are meant for
// idle periods.
// ---------------------------------------------------------------------------
module lease_credit_pool_core #(
    parameter int CREDITS   = 16,
    parameter int TAG_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_plan_id,
    input  logic [1:0]  i_plan_kind,
    input  logic [7:0]  i_record_count,
    input  logic [15:0] i_slot_count,
    input  logic [31:0] i_byte_count,
    input  logic [7:0]  i_lease_index,
    input  logic [31:0] i_lease_tag,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_granted_index,
    output logic [31:0] o_granted_tag,
    output logic [8:0]  o_free_count
);

    lcp_pkg::t_dp_cmd  w_cmd;
    lcp_pkg::t_dp_stat w_stat;

    // Request sequencer
    lcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Credit datapath
    lcp_dp #(
        .CREDITS   (CREDITS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_code      (i_cmd),
        .i_plan_id       (i_plan_id),
        .i_plan_kind     (i_plan_kind),
        .i_record_count  (i_record_count),
        .i_slot_count    (i_slot_count),
        .i_byte_count    (i_byte_count),
        .i_lease_index   (i_lease_index),
        .i_lease_tag     (i_lease_tag),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_granted_tag   (o_granted_tag),
        .o_free_count    (o_free_count)
    );

endmodule

// ===== bench/tb_lease_credit_pool_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lease_credit_pool_core: self-checking bench for the lease credit pool
// Drives acquire, commit, abort, transfer and release requests through the
// start/busy handshake, predicts each result with a bench-side copy of the
// credit pool and compares every o_done result field by field. Directed
// requests hit the envelope limits and each lifecycle transition; random
// requests mostly walk well-formed lease sequences under several limit
// settings, mixed with corrupted leases and raw noise.
// ---------------------------------------------------------------------------
module tb_lease_credit_pool_core;
    import lcp_pkg::*;

    localparam int          CLK_PERIOD     = 4;
    localparam int          NCRED          = 16;
    localparam int          WD_LIMIT       = 1000;
    localparam int          GAP_CAP        = 24;
    localparam logic [1:0]  KIND_OTHER     = 2'd2;
    localparam logic [2:0]  OP_ILLEGAL_LO  = 3'd5;
    localparam logic [2:0]  OP_ILLEGAL_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] plan;
        logic [1:0]  kind;
        logic [7:0]  recs;
        logic [15:0] slots;
        logic [31:0] bytes;
        logic [7:0]  idx;
        logic [31:0] tag;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  gidx;
        logic [31:0] gtag;
        logic [8:0]  free;
    } t_res;

    // DUT signals; the inputs are all known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_idx      = 1'b0;
    logic [31:0] i_cfg_wdata    = '0;
    logic        start          = 1'b0;
    logic        busy;
    logic [2:0]  i_cmd          = '0;
    logic [31:0] i_plan_id      = '0;
    logic [1:0]  i_plan_kind    = '0;
    logic [7:0]  i_record_count = '0;
    logic [15:0] i_slot_count   = '0;
    logic [31:0] i_byte_count   = '0;
    logic [7:0]  i_lease_index  = '0;
    logic [31:0] i_lease_tag    = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [7:0]  o_granted_index;
    logic [31:0] o_granted_tag;
    logic [8:0]  o_free_count;

    // Bench copy of the credit pool and its limits
    t_life       cr_life  [NCRED];
    logic [31:0] cr_gen   [NCRED];
    logic [31:0] cr_owner [NCRED];
    logic [2:0]  cr_recs  [NCRED];
    logic [15:0] cr_slots [NCRED];
    logic [31:0] cr_bytes [NCRED];
    logic [15:0] lim_slots;
    logic [31:0] lim_bytes;

    t_res        pending_results[$];
    int          idle_pct;
    int          n_requests;
    int          n_checked;
    int          n_mismatch;
    int          n_cfg_writes;
    int          stall_cycles;
    int          status_hits[8];

    lease_credit_pool_core #(
        .CREDITS   (NCRED),
        .TAG_WIDTH (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_plan_id       (i_plan_id),
        .i_plan_kind     (i_plan_kind),
        .i_record_count  (i_record_count),
        .i_slot_count    (i_slot_count),
        .i_byte_count    (i_byte_count),
        .i_lease_index   (i_lease_index),
        .i_lease_tag     (i_lease_tag),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_granted_tag   (o_granted_tag),
        .o_free_count    (o_free_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Check the named lease for exact identity against the expected state
    function automatic logic [2:0] lease_status(input t_req r, input t_life want);
        int k;
        if (r.idx >= NCRED)
            return RC_STALE;
        k = int'(r.idx);
        if (cr_life[k] != want || cr_gen[k] != r.tag || cr_owner[k] != r.plan ||
            cr_recs[k] != r.recs || cr_slots[k] != r.slots || cr_bytes[k] != r.bytes)
            return RC_DRIFTED;
        return RC_OK;
    endfunction

    // Apply one request to the bench pool and return the result it gives
    function automatic t_res pool_apply(input t_req r);
        t_res       res;
        logic [2:0] limit;
        logic       owned;
        int         hit;
        int         k;
        res   = '0;
        owned = 1'b0;
        hit   = -1;
        k     = int'(r.idx);
        case (r.cmd)
            OP_ACQUIRE: begin
                limit = (r.kind == KIND_SINGLE) ? LIMIT_SINGLE :
                        (r.kind == KIND_FIVE)   ? LIMIT_FIVE : LIMIT_OTHER;
                if (r.plan == 0 || r.recs > {5'd0, limit} || r.slots == 0 ||
                    r.slots > lim_slots || r.bytes == 0 || r.bytes > lim_bytes) begin
                    res.status = RC_ENVELOPE;
                end else begin
                    for (int i = 0; i < NCRED; i++) begin
                        if (cr_life[i] != LS_FREE && cr_owner[i] == r.plan)
                            owned = 1'b1;
                        if (hit < 0 && cr_life[i] == LS_FREE)
                            hit = i;
                    end
                    if (owned) begin
                        res.status = RC_OWNED;
                    end else if (hit < 0) begin
                        res.status = RC_EXHAUSTED;
                    end else if (cr_gen[hit] == '1) begin
                        res.status = RC_WRAPPED;
                    end else begin
                        cr_gen[hit]   = cr_gen[hit] + 32'd1;
                        cr_life[hit]  = LS_PREP;
                        cr_owner[hit] = r.plan;
                        cr_recs[hit]  = r.recs[2:0];
                        cr_slots[hit] = r.slots;
                        cr_bytes[hit] = r.bytes;
                        res.status    = RC_OK;
                        res.gidx      = 8'(hit);
                        res.gtag      = cr_gen[hit];
                    end
                end
            end
            OP_COMMIT: begin
                res.status = lease_status(r, LS_PREP);
                if (res.status == RC_OK)
                    cr_life[k] = LS_COMM;
            end
            OP_ABORT: begin
                // abort frees the credit but keeps its other fields
                res.status = lease_status(r, LS_PREP);
                if (res.status == RC_OK)
                    cr_life[k] = LS_FREE;
            end
            OP_TRANSFER: begin
                res.status = lease_status(r, LS_COMM);
                if (res.status == RC_OK)
                    cr_life[k] = LS_XFER;
            end
            OP_RELEASE: begin
                res.status = lease_status(r, LS_XFER);
                if (res.status == RC_OK) begin
                    cr_life[k]  = LS_FREE;
                    cr_owner[k] = '0;
                    cr_recs[k]  = '0;
                    cr_slots[k] = '0;
                    cr_bytes[k] = '0;
                end
            end
            default: res.status = RC_ENVELOPE;
        endcase
        for (int i = 0; i < NCRED; i++)
            if (cr_life[i] == LS_FREE)
                res.free = res.free + 9'd1;
        return res;
    endfunction

    function automatic t_req mk_acquire(input logic [31:0] plan, input logic [1:0] kind,
                                        input logic [7:0] recs, input logic [15:0] slots,
                                        input logic [31:0] bytes);
        t_req r;
        r.cmd   = OP_ACQUIRE;
        r.plan  = plan;
        r.kind  = kind;
        r.recs  = recs;
        r.slots = slots;
        r.bytes = bytes;
        r.idx   = 8'($urandom());
        r.tag   = $urandom();
        return r;
    endfunction

    // Build a lease request that names credit k exactly as the pool holds it
    function automatic t_req mk_lease(input logic [2:0] cmd, input int k);
        t_req r;
        r.cmd   = cmd;
        r.plan  = cr_owner[k];
        r.kind  = 2'($urandom());
        r.recs  = {5'd0, cr_recs[k]};
        r.slots = cr_slots[k];
        r.bytes = cr_bytes[k];
        r.idx   = 8'(k);
        r.tag   = cr_gen[k];
        return r;
    endfunction

    // Pick the next random request: mostly well-formed lease traffic
    function automatic t_req next_random_req(input int acq_pct);
        t_req       r;
        int         roll;
        int         k;
        int         live[$];
        logic [2:0] cmd;
        logic [2:0] limit;
        roll = $urandom_range(0, 99);
        for (int i = 0; i < NCRED; i++)
            if (cr_life[i] != LS_FREE)
                live.push_back(i);
        if (roll < 12) begin
            // raw noise across every field
            r.cmd   = 3'($urandom_range(0, 7));
            r.plan  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 24)) : $urandom();
            r.kind  = 2'($urandom());
            r.recs  = 8'($urandom());
            r.slots = 16'($urandom());
            r.bytes = $urandom();
            r.idx   = ($urandom_range(0, 1) == 0) ? 8'($urandom()) :
                                                    8'($urandom_range(0, NCRED - 1));
            r.tag   = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 40));
        end else if (roll < 12 + acq_pct || live.size() == 0) begin
            case ($urandom_range(0, 9))
                0:       r.kind = KIND_OTHER;
                1, 2, 3: r.kind = KIND_SINGLE;
                default: r.kind = KIND_FIVE;
            endcase
            limit = (r.kind == KIND_SINGLE) ? LIMIT_SINGLE :
                    (r.kind == KIND_FIVE)   ? LIMIT_FIVE : LIMIT_OTHER;
            r = mk_acquire(($urandom_range(0, 99) < 65) ? 32'($urandom_range(1, 24)) :
                           ($urandom_range(0, 99) < 8)  ? 32'd0 : $urandom(),
                           r.kind,
                           ($urandom_range(0, 99) < 8) ? 8'($urandom()) :
                                                         8'($urandom_range(0, limit)),
                           16'($urandom_range(1, lim_slots)),
                           $urandom_range(1, lim_bytes));
            // push the limits now and then
            case ($urandom_range(0, 19))
                0: r.slots = 16'd0;
                1: r.slots = lim_slots;
                2: r.slots = lim_slots + 16'd1;
                3: r.bytes = 32'd0;
                4: r.bytes = lim_bytes;
                5: r.bytes = lim_bytes + 32'd1;
                default: ;
            endcase
        end else begin
            k = live[$urandom_range(0, live.size() - 1)];
            case (cr_life[k])
                LS_PREP: cmd = ($urandom_range(0, 99) < 70) ? OP_COMMIT : OP_ABORT;
                LS_COMM: cmd = OP_TRANSFER;
                default: cmd = OP_RELEASE;
            endcase
            r = mk_lease(cmd, k);
            if ($urandom_range(0, 99) < 10) begin
                case ($urandom_range(0, 5))
                    0:       r.plan  ^= 32'd1 << $urandom_range(0, 31);
                    1:       r.recs  ^= 8'd1 << $urandom_range(0, 7);
                    2:       r.slots ^= 16'd1 << $urandom_range(0, 15);
                    3:       r.bytes ^= 32'd1 << $urandom_range(0, 31);
                    4:       r.tag   ^= 32'd1 << $urandom_range(0, 31);
                    default: r.idx    = 8'($urandom_range(0, NCRED - 1));
                endcase
            end
        end
        return r;
    endfunction

    // Send one request: optional idle gap, then hold until the block takes it
    task automatic issue_request(input t_req r);
        int   gap;
        t_res res;
        gap = 0;
        while (idle_pct > 0 && gap < GAP_CAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= r.cmd;
        i_plan_id      <= r.plan;
        i_plan_kind    <= r.kind;
        i_record_count <= r.recs;
        i_slot_count   <= r.slots;
        i_byte_count   <= r.bytes;
        i_lease_index  <= r.idx;
        i_lease_tag    <= r.tag;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        res = pool_apply(r);
        pending_results.push_back(res);
        status_hits[res.status]++;
        n_requests++;
    endtask

    // Drop start and hold until every pending result is back
    task automatic hold_until_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic idx, input logic [31:0] value);
        hold_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (idx == CFG_MAX_SLOTS)
            lim_slots = value[15:0];
        else
            lim_bytes = value;
        n_cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            // alternate fill and drain bursts so the pool swings full and empty
            issue_request(next_random_req(((n / 40) % 2 == 0) ? 60 : 15));
            if (n % 50 == 49)
                hold_until_drained();
        end
    endtask

    task automatic test_acquire_envelope();
        issue_request(mk_acquire(32'd0, KIND_SINGLE, 8'd1, 16'd1, 32'd1));
        issue_request(mk_acquire(32'd7, KIND_SINGLE, 8'd2, 16'd1, 32'd1));
        issue_request(mk_acquire(32'd7, KIND_FIVE, 8'd6, 16'd1, 32'd1));
        issue_request(mk_acquire(32'd7, KIND_OTHER, 8'd1, 16'd1, 32'd1));
        issue_request(mk_acquire(32'd7, KIND_SINGLE, 8'd1, 16'd0, 32'd1));
        issue_request(mk_acquire(32'd7, KIND_SINGLE, 8'd1, 16'd1, 32'd0));
        // unknown commands change nothing
        issue_request(mk_lease(OP_ILLEGAL_LO, 0));
        issue_request(mk_lease(OP_ILLEGAL_HI, 0));
    endtask

    task automatic test_lease_lifecycle();
        t_req r;
        // the generation-at-maximum case needs 2^32 acquires on one credit
        // and is left to the predictor only
        issue_request(mk_acquire(32'hFFFF_FFFF, KIND_OTHER, 8'd0, 16'hFFFF, 32'hFFFF_FFFF));
        issue_request(mk_acquire(32'hFFFF_FFFF, KIND_SINGLE, 8'd1, 16'd1, 32'd1));
        issue_request(mk_acquire(32'd1, KIND_FIVE, 8'd5, 16'd3, 32'd9));
        r = mk_lease(OP_COMMIT, 0);
        r.tag ^= 32'd1;
        issue_request(r);
        issue_request(mk_lease(OP_RELEASE, 0));
        issue_request(mk_lease(OP_COMMIT, 0));
        issue_request(mk_lease(OP_TRANSFER, 0));
        issue_request(mk_lease(OP_RELEASE, 0));
        issue_request(mk_lease(OP_ABORT, 1));
        issue_request(mk_lease(OP_COMMIT, 1));
        // aborted credit keeps its plan but no longer owns it
        issue_request(mk_acquire(32'd1, KIND_SINGLE, 8'd1, 16'd2, 32'd4));
        r = mk_lease(OP_COMMIT, 0);
        r.idx = 8'(NCRED);
        issue_request(r);
        r.idx = 8'hFF;
        issue_request(r);
        hold_until_drained();
    endtask

    task automatic test_tight_limits();
        write_limit(CFG_MAX_SLOTS, {16'($urandom()), 16'd1});
        write_limit(CFG_MAX_BYTES, 32'd1);
        run_random(60);
    endtask

    task automatic test_random_light_idle();
        idle_pct = 13;
        write_limit(CFG_MAX_SLOTS, {16'($urandom()), 16'($urandom_range(2, 65534))});
        write_limit(CFG_MAX_BYTES, $urandom_range(2, 32'hFFFF_FFFE));
        run_random(165);
    endtask

    task automatic test_random_heavy_idle();
        idle_pct = 78;
        write_limit(CFG_MAX_SLOTS, {16'($urandom()), 16'($urandom_range(1, 8))});
        write_limit(CFG_MAX_BYTES, $urandom_range(1, 1000));
        run_random(165);
    endtask

    task automatic test_random_back_to_back();
        idle_pct = 0;
        write_limit(CFG_MAX_SLOTS, {16'($urandom()), 16'hFFFF});
        write_limit(CFG_MAX_BYTES, 32'hFFFF_FFFF);
        run_random(165);
    endtask

    // Check each result against the oldest pending prediction
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result status=%0d idx=%0d tag=%h free=%0d",
                             o_status, o_granted_index, o_granted_tag, o_free_count);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_status !== want.status || o_granted_index !== want.gidx ||
                    o_granted_tag !== want.gtag || o_free_count !== want.free) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"ERROR: result %0d exp status=%0d idx=%0d tag=%h free=%0d",
                                  " got status=%0d idx=%0d tag=%h free=%0d"},
                                 n_checked, want.status, want.gidx, want.gtag, want.free,
                                 o_status, o_granted_index, o_granted_tag, o_free_count);
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WD_LIMIT) begin
            $display("Timeout after %0d idle cycles, %0d results pending",
                     stall_cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NCRED; i++) begin
            cr_life[i]  = LS_FREE;
            cr_gen[i]   = '0;
            cr_owner[i] = '0;
            cr_recs[i]  = '0;
            cr_slots[i] = '0;
            cr_bytes[i] = '0;
        end
        lim_slots    = 16'hFFFF;
        lim_bytes    = 32'hFFFF_FFFF;
        idle_pct     = 13;
        n_requests   = 0;
        n_checked    = 0;
        n_mismatch   = 0;
        n_cfg_writes = 0;
        stall_cycles = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_acquire_envelope();
        test_lease_lifecycle();
        test_tight_limits();
        test_random_light_idle();
        test_random_heavy_idle();
        test_random_back_to_back();

        hold_until_drained();
        repeat (NCRED + 8) @(posedge i_clk);
        if (pending_results.size() != 0)
            n_mismatch++;

        $display("Sent %0d requests, checked %0d results, %0d limit writes, %0d mismatches",
                 n_requests, n_checked, n_cfg_writes, n_mismatch);
        $display("Status mix: ok=%0d envelope=%0d owned=%0d exhausted=%0d stale=%0d drifted=%0d",
                 status_hits[RC_OK], status_hits[RC_ENVELOPE], status_hits[RC_OWNED],
                 status_hits[RC_EXHAUSTED], status_hits[RC_STALE], status_hits[RC_DRIFTED]);
        if (n_mismatch == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
